>>> rtl/bfct_pkg.sv
// Shared types, constants and the arctangent table of the body frame corner transform.
package bfct_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 12;
  localparam int COORD_WIDTH_DEF     = 24;
  localparam int ANGLE_W             = 16;
  localparam int DIM_W               = 16;
  localparam int TRIG_W              = 17;
  localparam int MAT_W               = 34;
  localparam int CORDIC_W            = 34;
  localparam int CORDIC_STEPS        = 30;
  localparam int CFG_IDX_W           = 1;
  localparam int CFG_DATA_W          = 16;

  localparam logic [63:0] Q30_TWO_PI      = 64'd6746518852;
  localparam logic [63:0] Q30_PI          = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI     = 64'd1686629713;
  localparam logic [63:0] CORDIC_GAIN_INV = 64'd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_BODY_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_LENGTH = 1'd1;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef struct packed {
    logic signed [MAT_W-1:0] r00;
    logic signed [MAT_W-1:0] r02;
    logic signed [MAT_W-1:0] r10;
    logic signed [MAT_W-1:0] r12;
    logic signed [MAT_W-1:0] r20;
    logic signed [MAT_W-1:0] r22;
  } mat_t;

  function automatic int red_steps(input int frac_bits);
    return (frac_bits < 13) ? 13 - frac_bits : 1;
  endfunction

  function automatic int trig_latency(input int frac_bits);
    return red_steps(frac_bits) + CORDIC_STEPS + 3;
  endfunction

  function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      default: v = 32'd1 << (30 - idx);
    endcase
    return signed'(CORDIC_W'(v));
  endfunction

endpackage

>>> rtl/bfct_in_if.sv
// Pose input channel: valid, ready and the angle and position fields.
interface bfct_in_if import bfct_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_W-1:0]     roll_angle;
  logic signed [ANGLE_W-1:0]     pitch_angle;
  logic signed [ANGLE_W-1:0]     yaw_angle;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source(output valid, roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z,
               output ready);
endinterface

>>> rtl/bfct_out_if.sv
// Corner result channel: valid, ready and the corner fields.
interface bfct_out_if import bfct_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    corner_index;
  logic signed [COORD_WIDTH-1:0] world_x;
  logic signed [COORD_WIDTH-1:0] world_y;
  logic signed [COORD_WIDTH-1:0] world_z;
  logic                          last_corner;

  modport source(output valid, corner_index, world_x, world_y, world_z, last_corner,
                 input ready);
  modport sink(input valid, corner_index, world_x, world_y, world_z, last_corner,
               output ready);
endinterface

>>> rtl/bfct_trig.sv
// Pipelined angle reduction and CORDIC giving Q15 cosine and sine of one angle.
module bfct_trig import bfct_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic signed [TRIG_W-1:0]  cos_q15,
  output logic signed [TRIG_W-1:0]  sin_q15
);

  localparam int RW = ANGLE_W + 30 - ANGLE_FRAC_BITS;
  localparam int RS = red_steps(ANGLE_FRAC_BITS);
  localparam logic signed [35:0] PI36      = signed'(36'(Q30_PI));
  localparam logic signed [35:0] TWO_PI36  = signed'(36'(Q30_TWO_PI));
  localparam logic signed [35:0] HALF_PI36 = signed'(36'(Q30_HALF_PI));

  logic [RW-1:0]                red_m_r [0:RS];
  logic                         red_n_r [0:RS];
  logic signed [CORDIC_W-1:0]   x_r [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]   y_r [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]   z_r [0:CORDIC_STEPS];
  logic                         f_r [0:CORDIC_STEPS];
  logic signed [TRIG_W-1:0]     cos_r;
  logic signed [TRIG_W-1:0]     sin_r;

  logic signed [RW-1:0] scaled;
  logic signed [35:0]   fold_v;
  logic                 fold_f;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [CORDIC_W-1:0] xr;
  logic signed [CORDIC_W-1:0] yr;

  always_comb begin
    scaled = RW'(angle) <<< (30 - ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_n_r[0] <= angle[ANGLE_W-1];
      red_m_r[0] <= angle[ANGLE_W-1] ? RW'(-scaled) : RW'(scaled);
    end
  end

  genvar j;
  generate
    for (j = 0; j < RS; j++) begin : g_red
      localparam logic [63:0] STEP = Q30_TWO_PI << (RS - 1 - j);
      logic [63:0] ext;
      always_comb begin
        ext = 64'(red_m_r[j]);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          red_n_r[j+1] <= red_n_r[j];
          red_m_r[j+1] <= (ext >= STEP) ? RW'(ext - STEP) : red_m_r[j];
        end
      end
    end
  endgenerate

  always_comb begin
    fold_v = signed'(36'(red_m_r[RS]));
    if (red_n_r[RS]) begin
      fold_v = -fold_v;
    end
    if (fold_v > PI36) begin
      fold_v = fold_v - TWO_PI36;
    end else if (fold_v < -PI36) begin
      fold_v = fold_v + TWO_PI36;
    end
    fold_f = 1'b0;
    if (fold_v > HALF_PI36) begin
      fold_v = fold_v - PI36;
      fold_f = 1'b1;
    end else if (fold_v < -HALF_PI36) begin
      fold_v = fold_v + PI36;
      fold_f = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= signed'(CORDIC_W'(CORDIC_GAIN_INV));
      y_r[0] <= '0;
      z_r[0] <= CORDIC_W'(fold_v);
      f_r[0] <= fold_f;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      always_ff @(posedge clk) begin
        if (en) begin
          f_r[i+1] <= f_r[i];
          if (!z_r[i][CORDIC_W-1]) begin
            x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
            y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
            z_r[i+1] <= z_r[i] - atan_q30(i);
          end else begin
            x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
            y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
            z_r[i+1] <= z_r[i] + atan_q30(i);
          end
        end
      end
    end
  endgenerate

  always_comb begin
    xs = f_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    ys = f_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    xr = (xs + CORDIC_W'(1 << 14)) >>> 15;
    yr = (ys + CORDIC_W'(1 << 14)) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= xr[TRIG_W-1:0];
      sin_r <= yr[TRIG_W-1:0];
    end
  end

  assign cos_q15 = cos_r;
  assign sin_q15 = sin_r;

endmodule

>>> rtl/body_frame_corner_transform.sv
// Top level: pose in, rotation matrix pipeline, four transformed corners out.
//
// Each accepted pose yields four corner items (down-left, down-right, up-left,
// up-right; the fourth marked last), one per cycle while the output is not
// stalled; the pose pipeline holds while the serializer still has corners to emit.
// A pose reaches its first corner through angle scaling and modulo 2*pi
// reduction (RED_STEPS steps, RED_STEPS being 13 - ANGLE_FRAC_BITS, at least 1),
// a 30-stage CORDIC per angle, three matrix stages, then the corner hold
// register and two corner stages.
// The corner serializer sets the sustained pose rate.
module body_frame_corner_transform import bfct_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bfct_in_if.sink               in_pose,
  bfct_out_if.source            out_corner
);

  localparam int LAT = trig_latency(ANGLE_FRAC_BITS);
  localparam int FD  = LAT + 3;
  localparam int PW  = MAT_W + DIM_W + 1;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (COORD_WIDTH - 1));

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
  } pos_t;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] length_r;

  pos_t side_r [0:FD-1];
  logic v_r    [0:FD-1];

  logic signed [TRIG_W-1:0] cx, sx, cy, sy, cz, sz;

  logic signed [MAT_W-1:0] m1_r00_r, m1_r10_r, m1_r20_r, m1_r22_r;
  logic signed [MAT_W-1:0] m1_p1_r, m1_p2_r, m1_p3_r, m1_p4_r;
  logic signed [TRIG_W-1:0] m1_cx_r;
  logic signed [MAT_W-1:0] m2_r00_r, m2_r10_r, m2_r20_r, m2_r22_r, m2_p3_r, m2_p4_r;
  logic signed [MAT_W+TRIG_W-1:0] m2_a_r, m2_b_r;
  mat_t m3_r;

  mat_t       hold_mat_r;
  pos_t       hold_pos_r;
  logic       hold_v_r;
  logic [1:0] k_r;

  logic signed [PW-1:0] c1_p_r [0:5];
  pos_t       c1_pos_r;
  logic [1:0] c1_k_r;
  logic       c1_v_r;

  logic                          out_v_r;
  logic [1:0]                    out_k_r;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r, out_z_r;

  logic en;
  logic fen;
  logic emit;
  logic load;
  logic signed [DIM_W:0] ws, ls;
  logic signed [MAT_W+TRIG_W+1:0] sum02, sum12;
  logic signed [COORD_WIDTH-1:0] wx, wy, wz;

  function automatic logic signed [COORD_WIDTH-1:0] place(
    input logic signed [PW-1:0] pa,
    input logic signed [PW-1:0] pb,
    input logic signed [COORD_WIDTH-1:0] pos
  );
    logic signed [63:0] s;
    s = signed'(64'(pa)) + signed'(64'(pb)) + (64'sd1 <<< 30);
    s = (s >>> 31) + signed'(64'(pos));
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[COORD_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BODY_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_BODY_LENGTH: length_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign en   = !out_v_r || out_corner.ready;
  assign fen  = !v_r[FD-1] || (en && (!hold_v_r || k_r == CORNER_LAST));
  assign load = fen && v_r[FD-1];
  assign emit = en && hold_v_r;
  assign in_pose.ready = fen;

  bfct_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_trig_x (
    .clk(clk), .en(fen), .angle(in_pose.roll_angle), .cos_q15(cx), .sin_q15(sx)
  );
  bfct_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_trig_y (
    .clk(clk), .en(fen), .angle(in_pose.pitch_angle), .cos_q15(cy), .sin_q15(sy)
  );
  bfct_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_trig_z (
    .clk(clk), .en(fen), .angle(in_pose.yaw_angle), .cos_q15(cz), .sin_q15(sz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < FD; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (fen) begin
      v_r[0] <= in_pose.valid;
      for (int s = 1; s < FD; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      side_r[0] <= '{px: in_pose.pos_x, py: in_pose.pos_y, pz: in_pose.pos_z};
      for (int s = 1; s < FD; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  always_comb begin
    sum02 = (MAT_W+TRIG_W+2)'(m2_a_r) + ((MAT_W+TRIG_W+2)'(m2_p3_r) <<< 15)
            + (MAT_W+TRIG_W+2)'(1 << 14);
    sum12 = (MAT_W+TRIG_W+2)'(m2_b_r) - ((MAT_W+TRIG_W+2)'(m2_p4_r) <<< 15)
            + (MAT_W+TRIG_W+2)'(1 << 14);
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      m1_r00_r <= cz * cy;
      m1_r10_r <= sz * cy;
      m1_r20_r <= -(MAT_W'(sy) <<< 15);
      m1_r22_r <= cy * cx;
      m1_p1_r  <= cz * sy;
      m1_p2_r  <= sz * sy;
      m1_p3_r  <= sz * sx;
      m1_p4_r  <= cz * sx;
      m1_cx_r  <= cx;
      m2_a_r   <= m1_p1_r * m1_cx_r;
      m2_b_r   <= m1_p2_r * m1_cx_r;
      m2_r00_r <= m1_r00_r;
      m2_r10_r <= m1_r10_r;
      m2_r20_r <= m1_r20_r;
      m2_r22_r <= m1_r22_r;
      m2_p3_r  <= m1_p3_r;
      m2_p4_r  <= m1_p4_r;
      m3_r.r00 <= m2_r00_r;
      m3_r.r10 <= m2_r10_r;
      m3_r.r20 <= m2_r20_r;
      m3_r.r22 <= m2_r22_r;
      m3_r.r02 <= MAT_W'(sum02 >>> 15);
      m3_r.r12 <= MAT_W'(sum12 >>> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      k_r      <= '0;
    end else if (load) begin
      hold_v_r <= 1'b1;
      k_r      <= '0;
    end else if (emit) begin
      k_r <= k_r + 2'd1;
      if (k_r == CORNER_LAST) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_mat_r <= m3_r;
      hold_pos_r <= side_r[FD-1];
    end
  end

  always_comb begin
    ws = k_r[0] ? signed'({1'b0, width_r}) : -signed'({1'b0, width_r});
    ls = k_r[1] ? signed'({1'b0, length_r}) : -signed'({1'b0, length_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r  <= emit;
      out_v_r <= c1_v_r;
    end
  end

  always_comb begin
    wx = place(c1_p_r[0], c1_p_r[1], c1_pos_r.px);
    wy = place(c1_p_r[2], c1_p_r[3], c1_pos_r.py);
    wz = place(c1_p_r[4], c1_p_r[5], c1_pos_r.pz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p_r[0] <= hold_mat_r.r00 * ws;
      c1_p_r[1] <= hold_mat_r.r02 * ls;
      c1_p_r[2] <= hold_mat_r.r10 * ws;
      c1_p_r[3] <= hold_mat_r.r12 * ls;
      c1_p_r[4] <= hold_mat_r.r20 * ws;
      c1_p_r[5] <= hold_mat_r.r22 * ls;
      c1_pos_r  <= hold_pos_r;
      c1_k_r    <= k_r;
      out_k_r   <= c1_k_r;
      out_x_r   <= wx;
      out_y_r   <= wy;
      out_z_r   <= wz;
    end
  end

  assign out_corner.valid        = out_v_r;
  assign out_corner.corner_index = out_k_r;
  assign out_corner.world_x      = out_x_r;
  assign out_corner.world_y      = out_y_r;
  assign out_corner.world_z      = out_z_r;
  assign out_corner.last_corner  = (out_k_r == CORNER_LAST);

endmodule

>>> rtl/bfct_checker.sv
// Port-level assertions of the corner transform and their bind.
module bfct_checker import bfct_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] corner_index,
  input logic       last_corner
);

  a_last_marks_fourth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_corner == (corner_index == CORNER_LAST)))
    else $error("last_corner does not match corner_index");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(corner_index))
    else $error("stalled item changed");

  a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && corner_index != CORNER_LAST) ##1 out_valid
    |-> corner_index == 2'($past(corner_index) + 2'd1))
    else $error("corner out of order");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item after reset");

endmodule

bind body_frame_corner_transform bfct_checker u_bfct_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_corner.valid),
  .out_ready(out_corner.ready),
  .corner_index(out_corner.corner_index),
  .last_corner(out_corner.last_corner)
);
